// ===== src/signed_decimal_ascii_formatter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed decimal formatter
// Shorthand for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_ASCII_FORMATTER_MACROS_SVH
`define SIGNED_DECIMAL_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SDAF_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SDAF_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== src/sdaf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdaf_pkg
// Shared types and constants for the signed decimal ASCII formatter.
// ----------------------------------------------------------------------------
package sdaf_pkg;

    // Default and upper limit of the digit count
    localparam int MAX_DIGITS_DEF = 10;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 4;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    // Reciprocal of ten: q = (x * RECIP_10) >> RECIP_SHIFT, exact for 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage

// ===== src/signed_decimal_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter
// Formats a signed 32-bit value as a sign character and N decimal digits.
// ----------------------------------------------------------------------------
// Each number is taken in one transfer and leaves as 1 + N characters, a sign
// ('+' or '-') then N digits, most significant first, with tlast on the final
// one. N is the digit count saturated to MAX_DIGITS; digits above N are
// dropped, so the output is the magnitude modulo 10^N, zero padded. A number
// is handled in two phases: first a shared divide-by-ten unit (a 32x32
// reciprocal multiplier) peels one digit per cycle into a small digit store,
// then its sign and digit characters are presented through the output
// register, one per cycle while the sink keeps tready high. The input is ready
// again once the final character has been loaded
// into the output register, so the next number's digits are worked out while
// that character still waits to be taken.
// ----------------------------------------------------------------------------
`include "signed_decimal_ascii_formatter_macros.svh"

module signed_decimal_ascii_formatter #(
    parameter int MAX_DIGITS = sdaf_pkg::MAX_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value, [35:32] digit_count, [39:36] zero
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_byte
    output logic        m_tlast    // last
);

    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int VW        = sdaf_pkg::VALUE_W;
    localparam int DW        = sdaf_pkg::DIGIT_W;
    localparam int CW        = sdaf_pkg::CHAR_W;
    localparam int COUNT_W_C = sdaf_pkg::COUNT_W;

    // State and control registers
    sdaf_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             sign_pend_reg, sign_pend_next;
    logic             neg_reg, neg_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers
    logic [VW-1:0]    mag_reg, mag_next;
    logic [CW-1:0]    out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;
    logic [DW-1:0]    digits_reg [MAX_DIGITS];

    // Datapath signals
    logic                    accept;
    logic                    load;
    logic                    digit_we;
    logic [COUNT_W_C-1:0]    count_in;
    logic [CNT_W-1:0]        count_sat;
    logic [2*VW-1:0]         product;
    logic [VW-1:0]           quot;
    logic [DW-1:0]           ten_q;
    logic [DW-1:0]           rem;
    logic [CNT_W-1:0]        left_m1;
    logic [DW-1:0]           digit_rd;

    assign accept   = s_tvalid && s_tready;
    assign load     = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == sdaf_pkg::ST_IDLE);

    // Digit count saturation
    assign count_in  = s_tdata[VW +: COUNT_W_C];
    assign count_sat = (count_in > COUNT_W_C'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                          : CNT_W'(count_in);

    // Shared divide-by-ten unit: quotient by reciprocal, remainder mod 16
    assign product = {{VW{1'b0}}, mag_reg} * {{VW{1'b0}}, sdaf_pkg::RECIP_10};
    assign quot    = VW'(product >> sdaf_pkg::RECIP_SHIFT);
    assign ten_q   = DW'({quot[DW-1:0], 3'b000}) + DW'({quot[DW-1:0], 1'b0});
    assign rem     = mag_reg[DW-1:0] - ten_q;

    // Digit store read, highest remaining digit first
    assign left_m1  = left_reg - 1'b1;
    assign digit_rd = digits_reg[left_m1[IDX_W-1:0]];

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdaf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sdaf_pkg::ST_DIVIDE;
                end
            end
            sdaf_pkg::ST_DIVIDE:
            begin
                if (step_reg == cnt_reg)
                begin
                    state_next = sdaf_pkg::ST_EMIT;
                end
            end
            sdaf_pkg::ST_EMIT:
            begin
                if (load)
                begin
                    if (sign_pend_reg ? (cnt_reg == '0) : (left_reg == CNT_W'(1)))
                    begin
                        state_next = sdaf_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sdaf_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic
    always_comb
    begin
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        left_next      = left_reg;
        sign_pend_next = sign_pend_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        digit_we       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            sdaf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next  = s_tdata[VW-1];
                    mag_next  = s_tdata[VW-1] ? (VW'(0) - s_tdata[VW-1:0]) : s_tdata[VW-1:0];
                    cnt_next  = count_sat;
                    step_next = '0;
                end
            end
            sdaf_pkg::ST_DIVIDE:
            begin
                if (step_reg == cnt_reg)
                begin
                    left_next      = cnt_reg;
                    sign_pend_next = 1'b1;
                end
                else
                begin
                    digit_we  = 1'b1;
                    mag_next  = quot;
                    step_next = step_reg + 1'b1;
                end
            end
            sdaf_pkg::ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (sign_pend_reg)
                    begin
                        out_data_next  = neg_reg ? sdaf_pkg::CHAR_MINUS : sdaf_pkg::CHAR_PLUS;
                        out_last_next  = (cnt_reg == '0);
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        out_data_next = sdaf_pkg::CHAR_ZERO + CW'(digit_rd);
                        out_last_next = (left_reg == CNT_W'(1));
                        left_next     = left_m1;
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdaf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            left_reg      <= '0;
            sign_pend_reg <= 1'b0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            left_reg      <= left_next;
            sign_pend_reg <= sign_pend_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Digit store, least significant digit at index zero
    always_ff @(posedge clk)
    begin
        if (digit_we)
        begin
            digits_reg[step_reg[IDX_W-1:0]] <= rem;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    `SDAF_ASSERT_NEXT(a_accept_divides, clk, rst_n, accept,
        state_reg == sdaf_pkg::ST_DIVIDE, "accepted number did not start dividing")
    `SDAF_ASSERT_IMPL(a_step_bound, clk, rst_n, state_reg == sdaf_pkg::ST_DIVIDE,
        step_reg <= cnt_reg && cnt_reg <= CNT_W'(MAX_DIGITS), "digit step overran count")
    `SDAF_ASSERT_IMPL(a_emit_has_work, clk, rst_n, state_reg == sdaf_pkg::ST_EMIT,
        sign_pend_reg || left_reg != '0, "emit state with nothing left to send")
    `SDAF_ASSERT_IMPL(a_digit_char, clk, rst_n,
        m_tvalid && m_tdata != sdaf_pkg::CHAR_PLUS && m_tdata != sdaf_pkg::CHAR_MINUS,
        m_tdata >= sdaf_pkg::CHAR_ZERO && m_tdata <= sdaf_pkg::CHAR_ZERO + 8'd9,
        "digit character out of range")

endmodule

// ===== dv/tb_signed_decimal_ascii_formatter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_decimal_ascii_formatter
// Self-checking testbench for the signed decimal ASCII formatter.
// ----------------------------------------------------------------------------
// Numbers go in on the input stream with random gaps. Each accepted number is
// turned into its expected sign and digit characters by a local formatter,
// and each character taken from the output stream is checked against the
// oldest expected one. Directed cases cover the field extremes, a zero digit
// count, saturated counts and the most negative value. Random numbers follow
// under three patterns of source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_signed_decimal_ascii_formatter;

    // One expected output character
    typedef struct packed {
        logic [sdaf_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } ascii_char_t;

    // Powers of ten that fit in 32 bits, used to aim values at digit borders
    localparam logic [31:0] POW10 [10] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [31:0] value, [35:32] digit_count, [39:36] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] char_byte
    logic        m_tlast;   // last

    ascii_char_t pending_chars[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    signed_decimal_ascii_formatter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock, 10 ns period
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Sink back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Expected characters for one number: sign, then count digits of the
    // magnitude modulo 10^count, most significant first
    task automatic format_number(input logic [31:0] value, input logic [3:0] digit_count);
        logic [31:0] magnitude;
        logic [3:0]  digits [sdaf_pkg::MAX_DIGITS_DEF];
        int          n;
        ascii_char_t c;
        begin
            magnitude = value[31] ? (32'd0 - value) : value;
            n = (digit_count > sdaf_pkg::MAX_DIGITS_DEF) ? sdaf_pkg::MAX_DIGITS_DEF
                                                         : int'(digit_count);
            for (int k = 0; k < n; k++)
            begin
                digits[n - 1 - k] = 4'(magnitude % 32'd10);
                magnitude = magnitude / 32'd10;
            end
            c.ch   = value[31] ? sdaf_pkg::CHAR_MINUS : sdaf_pkg::CHAR_PLUS;
            c.last = (n == 0);
            pending_chars.push_back(c);
            for (int k = 0; k < n; k++)
            begin
                c.ch   = sdaf_pkg::CHAR_ZERO + sdaf_pkg::CHAR_W'(digits[k]);
                c.last = (k == n - 1);
                pending_chars.push_back(c);
            end
        end
    endtask

    // Check each character transfer against the oldest expectation
    always @(posedge clk)
    begin
        ascii_char_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chars.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: unexpected character 0x%02h last=%0b",
                             $realtime, m_tdata, m_tlast);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (m_tdata !== want.ch || m_tlast !== want.last)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: char exp 0x%02h last %0b, got 0x%02h last %0b",
                                 $realtime, want.ch, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    // Send one number; s_tvalid stays high on return
    task automatic send_number(input logic [31:0] value, input logic [3:0] digit_count);
        begin
            @(negedge clk);
            while ($urandom_range(99, 0) < send_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {4'b0000, digit_count, value};
            do
                @(posedge clk);
            while (!s_tready);
            format_number(value, digit_count);
        end
    endtask

    // Stop sending until every expected character has come out
    task automatic wait_drained();
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            while (pending_chars.size() != 0)
                @(posedge clk);
        end
    endtask

    // Random value: full range, small, near digit borders or extreme
    function automatic logic [31:0] random_value();
        logic [31:0] v;
        begin
            case ($urandom_range(5, 0))
                0, 1: v = $urandom;
                2:    v = $urandom_range(99, 0);
                3:    v = POW10[$urandom_range(9, 0)] + $urandom_range(2, 0) - 32'd1;
                4:    v = 32'h8000_0000 + $urandom_range(3, 0);
                default: v = 32'h7FFF_FFFF - $urandom_range(3, 0);
            endcase
            if ($urandom_range(1, 0) && v != 32'h8000_0000)
                v = 32'd0 - v;
            return v;
        end
    endfunction

    function automatic logic [3:0] random_count();
        begin
            if ($urandom_range(99, 0) < 85)
                return 4'($urandom_range(10, 0));
            return 4'($urandom_range(15, 11));
        end
    endfunction

    // Field extremes and the zero digit count
    task automatic test_extremes();
        begin
            send_number(32'd0, 4'd0);
            send_number(32'd0, 4'd10);
            send_number(32'd1, 4'd1);
            send_number(32'hFFFF_FFFF, 4'd1);
            send_number(32'hFFFF_FFFB, 4'd0);
            send_number(32'h7FFF_FFFF, 4'd10);
            send_number(32'hFFFF_FFFF, 4'd10);
            send_number(32'd999999999, 4'd9);
            send_number(32'd1000000000, 4'd10);
        end
    endtask

    // Counts above the limit, and dropped high digits
    task automatic test_count_saturation();
        begin
            send_number(32'h7FFF_FFFF, 4'd11);
            send_number(-32'd987654321, 4'd12);
            send_number(32'd42, 4'd13);
            send_number(32'd5, 4'd14);
            send_number(32'd123456789, 4'd3);
            send_number(-32'd123456789, 4'd15);
        end
    endtask

    // Most negative value, whose magnitude does not fit a signed word
    task automatic test_most_negative();
        begin
            send_number(32'h8000_0000, 4'd10);
            send_number(32'h8000_0000, 4'd15);
            send_number(32'h8000_0000, 4'd4);
            send_number(32'h8000_0000, 4'd0);
        end
    endtask

    task automatic test_random(input int n_items);
        begin
            for (int i = 0; i < n_items; i++)
                send_number(random_value(), random_count());
        end
    endtask

    // Watchdog
    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        error_count   = 0;
        send_idle_pct = 33;
        recv_idle_pct = 79;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Slow sink
        test_extremes();
        test_count_saturation();
        test_most_negative();
        test_random(150);
        wait_drained();

        // Slow source
        send_idle_pct = 79;
        recv_idle_pct = 33;
        test_random(150);
        wait_drained();

        // Full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(150);
        wait_drained();
        repeat (50) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/sdaf_pkg.sv
src/signed_decimal_ascii_formatter.sv
dv/tb_signed_decimal_ascii_formatter.sv
